// File: design/roberts_cross_edge_magnitude_defines.svh
// ----------------------------------------------------------------------------
// Roberts cross edge magnitude: assertion macros
// Implication checks on a clock with a synchronous active-high reset.
// ----------------------------------------------------------------------------
`ifndef ROBERTS_CROSS_EDGE_MAGNITUDE_DEFINES_SVH
`define ROBERTS_CROSS_EDGE_MAGNITUDE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RCE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define RCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RCE_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RCE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: design/rce_pkg.sv
// ----------------------------------------------------------------------------
// rce_pkg
// Shared constants for the Roberts cross edge magnitude block.
// ----------------------------------------------------------------------------
package rce_pkg;
   localparam int MAX_WIDTH = 2048;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W     = 16;
   localparam int CFG_WW    = 12;
   localparam int CFG_DW    = 16;
   localparam int LUMA_W    = 18;
   localparam int PIX_W     = 8;
   localparam int SQ_W      = 36;
   localparam int RAD_W     = 38;
   localparam int ROOT_W    = 19;
   localparam int REM_W     = 21;
   localparam int STEPS     = RAD_W / 2;
   localparam int CNT_W     = $clog2(STEPS);
   localparam int FRAC_BITS = 10;
   localparam logic [0:0] REG_WIDTH  = 1'b0;
   localparam logic [0:0] REG_HEIGHT = 1'b1;
endpackage

// File: design/rce_stream_if.sv
// ----------------------------------------------------------------------------
// rce_req_if / rce_rsp_if
// Valid/ready channels for input pixels and result items.
// ----------------------------------------------------------------------------
interface rce_req_if;
   logic                     valid;
   logic                     ready;
   logic [rce_pkg::PIX_W-1:0] red;
   logic [rce_pkg::PIX_W-1:0] green;
   logic [rce_pkg::PIX_W-1:0] blue;
   logic [rce_pkg::PIX_W-1:0] alpha_in;
   modport source (output valid, red, green, blue, alpha_in, input ready);
   modport sink   (input valid, red, green, blue, alpha_in, output ready);
endinterface

interface rce_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [rce_pkg::PIX_W-1:0] gray;
   logic [rce_pkg::PIX_W-1:0] alpha_out;
   logic [rce_pkg::COL_W-1:0] out_column;
   logic [rce_pkg::ROW_W-1:0] out_row;
   logic                     last_of_run;
   modport source (output valid, gray, alpha_out, out_column, out_row, last_of_run,
                   input ready);
   modport sink   (input valid, gray, alpha_out, out_column, out_row, last_of_run,
                   output ready);
endinterface

// File: design/rce_ram.sv
// ----------------------------------------------------------------------------
// rce_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// File: design/rce_isqrt.sv
// ----------------------------------------------------------------------------
// rce_isqrt
// Integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module rce_isqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [rce_pkg::RAD_W-1:0]  radicand,
   output logic                       busy,
   output logic                       done,
   output logic [rce_pkg::ROOT_W-1:0] root
);
   logic [rce_pkg::RAD_W-1:0]  rad_ff, rad_in;
   logic [rce_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [rce_pkg::REM_W-1:0]  rem_ff, rem_in;
   logic [rce_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                       busy_ff, busy_in, done_ff, done_in;
   logic [rce_pkg::REM_W+1:0]  rem_sh, trial;

   always_comb begin
      rem_sh  = {rem_ff, rad_ff[rce_pkg::RAD_W-1 -: 2]};
      trial   = (rce_pkg::REM_W+2)'({root_ff, 2'b01});
      rad_in  = rad_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         root_in = '0;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[rce_pkg::RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rce_pkg::REM_W'(rem_sh - trial);
            root_in = {root_ff[rce_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rce_pkg::REM_W'(rem_sh);
            root_in = {root_ff[rce_pkg::ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == rce_pkg::CNT_W'(rce_pkg::STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign root = root_ff;
endmodule

// File: design/roberts_cross_edge_magnitude.sv
// ----------------------------------------------------------------------------
// roberts_cross_edge_magnitude
// Streaming Roberts cross gradient magnitude over RGBA raster pixels.
// ----------------------------------------------------------------------------
// One pixel is taken at a time. Each pixel goes through line-buffer reads and
// writes and steps through its four result slots. Each of its zero to four
// results goes through a square, a sum and a 19-step square root on the shared
// iterative square root, and may then wait for the one before it to leave the
// output register.
// The line buffers in block RAM need no clearing after reset. A finished
// result waits in the output register while the next pixel is taken.
module roberts_cross_edge_magnitude (
   input  logic                        clock,
   input  logic                        reset,
   rce_req_if.sink                     req_px,
   rce_rsp_if.source                   rsp_px,
   input  logic                        csr_write_enable,
   input  logic [0:0]                  csr_index,
   input  logic [rce_pkg::CFG_DW-1:0]  csr_data
);
`include "roberts_cross_edge_magnitude_defines.svh"

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RD2  = 4'd1;
   localparam logic [3:0] S_RD3  = 4'd2;
   localparam logic [3:0] S_WR   = 4'd3;
   localparam logic [3:0] S_SEL  = 4'd4;
   localparam logic [3:0] S_SQ   = 4'd5;
   localparam logic [3:0] S_SUM  = 4'd6;
   localparam logic [3:0] S_SQRT = 4'd7;
   localparam logic [3:0] S_OUT  = 4'd8;
   localparam logic [3:0] S_FIN  = 4'd9;

   localparam int CW = rce_pkg::COL_W;
   localparam int RW = rce_pkg::ROW_W;
   localparam int LW = rce_pkg::LUMA_W;
   localparam int PW = rce_pkg::PIX_W;

   logic [3:0] state_ff, state_in;
   logic [rce_pkg::CFG_WW-1:0] width_ff;
   logic [RW-1:0] height_ff;

   logic [CW-1:0] column_count_ff;
   logic [RW-1:0] row_count_ff;
   logic [LW-1:0] left_luma_ff, upper_left_ff;
   logic [PW-1:0] left_alpha_ff;

   logic [LW-1:0] luma_ff, ur_ff;
   logic [PW-1:0] a8_ff, uap_ff, ac_ff;
   logic [CW-1:0] c_ff;
   logic [RW-1:0] r_ff;
   logic          last_col_ff, last_row_ff;
   logic [3:0]    en_ff;
   logic [2:0]    k_ff;
   logic [rce_pkg::SQ_W-1:0] sqx_ff, sqy_ff;

   logic          rsp_valid_ff;
   logic [PW-1:0] gray_ff, alpha_o_ff;
   logic [CW-1:0] col_o_ff;
   logic [RW-1:0] row_o_ff;
   logic          last_o_ff;

   // accept-time decode
   logic [rce_pkg::CFG_WW-1:0] w_eff;
   logic [RW-1:0]  h_eff;
   logic [LW-1:0]  luma_c;
   logic           last_col_c, last_row_c, accept;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = rce_pkg::CFG_WW'(1);
      end else if (width_ff > rce_pkg::CFG_WW'(rce_pkg::MAX_WIDTH)) begin
         w_eff = rce_pkg::CFG_WW'(rce_pkg::MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      h_eff = (height_ff == '0) ? RW'(1) : height_ff;
      luma_c = LW'(req_px.red) * LW'(306) + LW'(req_px.green) * LW'(601)
             + LW'(req_px.blue) * LW'(117);
      last_col_c = ({1'b0, rce_pkg::CFG_WW'(column_count_ff)} + 1'b1)
                   >= {1'b0, w_eff};
      last_row_c = ({1'b0, row_count_ff} + 1'b1) >= {1'b0, h_eff};
   end

   assign req_px.ready = (state_ff == S_IDLE);
   assign accept = req_px.valid && req_px.ready;

   // line buffers
   logic [LW-1:0] luma_rd;
   logic [PW-1:0] alpha_rd, alpha_wdata;
   logic [CW-1:0] alpha_raddr, alpha_waddr;
   logic          alpha_we;

   always_comb begin
      alpha_raddr = (state_ff == S_IDLE) ? column_count_ff - 1'b1 : c_ff;
      alpha_we    = 1'b0;
      alpha_waddr = c_ff;
      alpha_wdata = a8_ff;
      if (state_ff == S_RD3) begin
         alpha_we    = (c_ff != '0);
         alpha_waddr = c_ff - 1'b1;
         alpha_wdata = left_alpha_ff;
      end else if (state_ff == S_WR) begin
         alpha_we = last_col_ff;
      end
   end

   rce_ram #(.WIDTH(LW), .DEPTH(rce_pkg::MAX_WIDTH)) u_luma_line (
      .clock (clock),
      .we    (state_ff == S_RD2),
      .waddr (c_ff),
      .wdata (luma_ff),
      .raddr (column_count_ff),
      .rdata (luma_rd)
   );

   rce_ram #(.WIDTH(PW), .DEPTH(rce_pkg::MAX_WIDTH)) u_alpha_line (
      .clock (clock),
      .we    (alpha_we),
      .waddr (alpha_waddr),
      .wdata (alpha_wdata),
      .raddr (alpha_raddr),
      .rdata (alpha_rd)
   );

   // operand select for the current result
   logic [LW-1:0] op_a, op_b, op_c, op_d;
   logic [PW-1:0] sel_alpha;
   logic [CW-1:0] sel_col;
   logic [RW-1:0] sel_row;
   logic          sel_last;
   logic signed [LW:0] gx, gy;
   logic signed [2*LW+1:0] px, py;

   always_comb begin
      case (k_ff[1:0])
         2'd0: begin
            op_a = upper_left_ff; op_b = ur_ff; op_c = left_luma_ff; op_d = luma_ff;
            sel_alpha = uap_ff;        sel_col = c_ff - 1'b1; sel_row = r_ff - 1'b1;
         end
         2'd1: begin
            op_a = ur_ff; op_b = ur_ff; op_c = luma_ff; op_d = luma_ff;
            sel_alpha = ac_ff;         sel_col = c_ff;        sel_row = r_ff - 1'b1;
         end
         2'd2: begin
            op_a = left_luma_ff; op_b = luma_ff; op_c = left_luma_ff; op_d = luma_ff;
            sel_alpha = left_alpha_ff; sel_col = c_ff - 1'b1; sel_row = r_ff;
         end
         default: begin
            op_a = luma_ff; op_b = luma_ff; op_c = luma_ff; op_d = luma_ff;
            sel_alpha = a8_ff;         sel_col = c_ff;        sel_row = r_ff;
         end
      endcase
      sel_last = 1'b1;
      for (int j = 0; j < 4; j++) begin
         if (j > int'(k_ff) && en_ff[j]) begin
            sel_last = 1'b0;
         end
      end
      gx = $signed({1'b0, op_d}) - $signed({1'b0, op_a});
      gy = $signed({1'b0, op_c}) - $signed({1'b0, op_b});
      px = gx * gx;
      py = gy * gy;
   end

   // square root
   logic [rce_pkg::ROOT_W-1:0] root;
   logic                       sq_busy, sq_done;
   logic [PW-1:0]              gray_c;

   rce_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_SUM),
      .radicand (rce_pkg::RAD_W'(sqx_ff) + rce_pkg::RAD_W'(sqy_ff)),
      .busy     (sq_busy),
      .done     (sq_done),
      .root     (root)
   );

   always_comb begin
      if (root[rce_pkg::ROOT_W-1:rce_pkg::FRAC_BITS] > (rce_pkg::ROOT_W-rce_pkg::FRAC_BITS)'(255))
      begin
         gray_c = 8'hFF;
      end else begin
         gray_c = PW'(root[rce_pkg::ROOT_W-1:rce_pkg::FRAC_BITS]);
      end
   end

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_px.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) state_in = S_RD2;
         S_RD2:  state_in = S_RD3;
         S_RD3:  state_in = S_WR;
         S_WR:   state_in = S_SEL;
         S_SEL: begin
            if (k_ff[2]) begin
               state_in = S_FIN;
            end else if (en_ff[k_ff[1:0]]) begin
               state_in = S_SQ;
            end
         end
         S_SQ:   state_in = S_SUM;
         S_SUM:  state_in = S_SQRT;
         S_SQRT: if (sq_done) state_in = S_OUT;
         S_OUT:  if (out_free) state_in = S_SEL;
         S_FIN:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         width_ff        <= rce_pkg::CFG_WW'(rce_pkg::MAX_WIDTH);
         height_ff       <= RW'(1);
         column_count_ff <= '0;
         row_count_ff    <= '0;
         left_luma_ff    <= '0;
         upper_left_ff   <= '0;
         left_alpha_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
         k_ff            <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            if (csr_index == rce_pkg::REG_WIDTH) begin
               width_ff <= csr_data[rce_pkg::CFG_WW-1:0];
            end else begin
               height_ff <= csr_data[RW-1:0];
            end
         end
         if (state_ff == S_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_px.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: k_ff <= '0;
            S_SEL: begin
               // skip disabled result slots
               if (!k_ff[2] && !en_ff[k_ff[1:0]]) begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            S_FIN: begin
               upper_left_ff <= ur_ff;
               left_luma_ff  <= luma_ff;
               left_alpha_ff <= a8_ff;
               if (last_col_ff) begin
                  column_count_ff <= '0;
                  row_count_ff    <= last_row_ff ? '0 : r_ff + 1'b1;
               end else begin
                  column_count_ff <= c_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         luma_ff     <= luma_c;
         a8_ff       <= req_px.alpha_in;
         c_ff        <= column_count_ff;
         r_ff        <= row_count_ff;
         last_col_ff <= last_col_c;
         last_row_ff <= last_row_c;
         en_ff[0]    <= (row_count_ff != '0) && (column_count_ff != '0);
         en_ff[1]    <= (row_count_ff != '0) && last_col_c;
         en_ff[2]    <= last_row_c && (column_count_ff != '0);
         en_ff[3]    <= last_row_c && last_col_c;
      end
      if (state_ff == S_RD2) begin
         ur_ff  <= luma_rd;
         uap_ff <= (c_ff != '0) ? alpha_rd : '0;
      end
      if (state_ff == S_RD3) begin
         ac_ff <= alpha_rd;
      end
      if (state_ff == S_SQ) begin
         sqx_ff <= px[rce_pkg::SQ_W-1:0];
         sqy_ff <= py[rce_pkg::SQ_W-1:0];
      end
      if (state_ff == S_OUT && out_free) begin
         gray_ff    <= gray_c;
         alpha_o_ff <= sel_alpha;
         col_o_ff   <= sel_col;
         row_o_ff   <= sel_row;
         last_o_ff  <= sel_last;
      end
   end

   assign rsp_px.valid       = rsp_valid_ff;
   assign rsp_px.gray        = gray_ff;
   assign rsp_px.alpha_out   = alpha_o_ff;
   assign rsp_px.out_column  = col_o_ff;
   assign rsp_px.out_row     = row_o_ff;
   assign rsp_px.last_of_run = last_o_ff;

   `RCE_ASSERT_NEXT(a_accept_busy, clock, reset, accept, !req_px.ready)
   `RCE_ASSERT_IMPL(a_rise_from_out, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_OUT)
   `RCE_ASSERT_IMPL(a_idle_no_sqrt, clock, reset, state_ff == S_IDLE, !sq_busy)
endmodule

// File: tb/sv/rce_edge_checker.sv
// ----------------------------------------------------------------------------
// rce_edge_checker
// Watches the pixel and result channels, predicts each pixel's edge results
// from luma line buffers and compares them field by field in order.
// ----------------------------------------------------------------------------
module rce_edge_checker (
   input  logic        clock,
   input  logic        reset,
   rce_req_if.sink     req_px,
   rce_rsp_if.sink     rsp_px,
   input  logic        csr_write_enable,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          error_count,
   output int          pending_count
);
   import rce_pkg::*;

   typedef struct packed {
      logic [7:0]       gray;
      logic [7:0]       alpha_out;
      logic [COL_W-1:0] out_column;
      logic [ROW_W-1:0] out_row;
      logic             last_of_run;
   } edge_result_type;

   edge_result_type  edge_expected_q[$];
   logic [LUMA_W-1:0] luma_mem[MAX_WIDTH];
   logic [7:0]       alpha_mem[MAX_WIDTH];
   logic [11:0]      width_reg;
   logic [15:0]      height_reg;
   int unsigned      col_pos, row_pos, left_y, left_a, up_left_y;

   function automatic logic [7:0] grad_mag(int unsigned a, int unsigned b,
                                           int unsigned c, int unsigned d);
      longint gx, gy;
      longint unsigned s, res, bitv;
      gx = longint'(d) - longint'(a);
      gy = longint'(c) - longint'(b);
      s = gx * gx + gy * gy;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv >>= 2;
      while (bitv != 0) begin
         if (s >= res + bitv) begin
            s -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      res >>= FRAC_BITS;
      return (res > 255) ? 8'd255 : res[7:0];
   endfunction

   task automatic predict_pixel(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8,
                                logic [7:0] a8);
      int unsigned w, h, c, r, y, up_right;
      bit last_col, last_row;
      edge_result_type res_list[$];
      edge_result_type e;
      w = (width_reg < 1) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
      h = (height_reg < 1) ? 1 : height_reg;
      y = 306 * r8 + 601 * g8 + 117 * b8;
      c = (col_pos > MAX_WIDTH - 1) ? MAX_WIDTH - 1 : col_pos;
      r = row_pos;
      last_col = (c + 1 >= w);
      last_row = (r + 1 >= h);
      up_right = luma_mem[c];
      if (r >= 1) begin
         if (c >= 1) begin
            e = '{grad_mag(up_left_y, up_right, left_y, y), alpha_mem[c-1],
                  COL_W'(c - 1), ROW_W'(r - 1), 1'b0};
            res_list.push_back(e);
         end
         if (last_col) begin
            e = '{grad_mag(up_right, up_right, y, y), alpha_mem[c], COL_W'(c),
                  ROW_W'(r - 1), 1'b0};
            res_list.push_back(e);
         end
      end
      if (last_row) begin
         if (c >= 1) begin
            e = '{grad_mag(left_y, y, left_y, y), 8'(left_a), COL_W'(c - 1),
                  ROW_W'(r), 1'b0};
            res_list.push_back(e);
         end
         if (last_col) begin
            e = '{8'd0, a8, COL_W'(c), ROW_W'(r), 1'b0};
            res_list.push_back(e);
         end
      end
      if (res_list.size() > 0) res_list[res_list.size()-1].last_of_run = 1'b1;
      foreach (res_list[i]) edge_expected_q.push_back(res_list[i]);
      // alpha line is written one column late
      if (c >= 1) alpha_mem[c-1] = 8'(left_a);
      if (last_col) alpha_mem[c] = a8;
      up_left_y = up_right;
      luma_mem[c] = LUMA_W'(y);
      left_y = y;
      left_a = a8;
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : ((r + 1) & 16'hFFFF);
      end else begin
         col_pos = c + 1;
      end
   endtask

   always @(posedge clock) begin
      edge_result_type got, want;
      if (reset) begin
         width_reg <= 12'd2048;
         height_reg <= 16'd1;
         col_pos = 0;
         row_pos = 0;
         left_y = 0;
         left_a = 0;
         up_left_y = 0;
         edge_expected_q.delete();
         error_count <= 0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == REG_WIDTH) width_reg <= csr_data[11:0];
            else height_reg <= csr_data;
         end
         if (req_px.valid && req_px.ready)
            predict_pixel(req_px.red, req_px.green, req_px.blue, req_px.alpha_in);
         if (rsp_px.valid && rsp_px.ready) begin
            got = '{rsp_px.gray, rsp_px.alpha_out, rsp_px.out_column, rsp_px.out_row,
                    rsp_px.last_of_run};
            if (edge_expected_q.size() == 0) begin
               $error("unexpected result item: %p", got);
               error_count <= error_count + 1;
            end else begin
               want = edge_expected_q.pop_front();
               if (got != want) begin
                  if (got.gray != want.gray)
                     $error("gray: expected %0d, got %0d", want.gray, got.gray);
                  if (got.alpha_out != want.alpha_out)
                     $error("alpha_out: expected %0d, got %0d", want.alpha_out,
                            got.alpha_out);
                  if (got.out_column != want.out_column)
                     $error("out_column: expected %0d, got %0d", want.out_column,
                            got.out_column);
                  if (got.out_row != want.out_row)
                     $error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
                  if (got.last_of_run != want.last_of_run)
                     $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                            got.last_of_run);
                  error_count <= error_count + 1;
               end
            end
         end
      end
      pending_count = edge_expected_q.size();
   end
endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Feeds raster frames of random and patterned RGBA pixels at several frame sizes and
// handshake loads; the checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb;
   import rce_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [0:0] csr_index = REG_WIDTH;
   logic [15:0] csr_data = '0;
   int error_count, pending_count;
   int send_idle_pct = 0, stall_pct = 0, hold_off = 0;

   rce_req_if req_px();
   rce_rsp_if rsp_px();

   roberts_cross_edge_magnitude i_dut (
      .clock, .reset, .req_px(req_px.sink), .rsp_px(rsp_px.source),
      .csr_write_enable, .csr_index, .csr_data
   );

   rce_edge_checker i_checker (
      .clock, .reset, .req_px(req_px.sink), .rsp_px(rsp_px.sink),
      .csr_write_enable, .csr_index, .csr_data, .error_count, .pending_count
   );

   always #6 clock = ~clock;

   initial begin
      req_px.valid = 1'b0;
      req_px.red = '0;
      req_px.green = '0;
      req_px.blue = '0;
      req_px.alpha_in = '0;
      rsp_px.ready = 1'b0;
   end

   // receiver: random stall, or a long counted hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_px.ready <= 1'b0;
      end else if (hold_off > 0) begin
         rsp_px.ready <= 1'b0;
         hold_off <= hold_off - 1;
      end else begin
         rsp_px.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic write_reg(logic [0:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_pixel(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8,
                             logic [7:0] a8);
      while ($urandom_range(99) < send_idle_pct) begin
         req_px.valid <= 1'b0;
         @(posedge clock);
      end
      req_px.valid <= 1'b1;
      req_px.red <= r8;
      req_px.green <= g8;
      req_px.blue <= b8;
      req_px.alpha_in <= a8;
      @(posedge clock);
      while (!req_px.ready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_px.valid <= 1'b0;
      // let the checker count the last pixel's results first
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      // pixels with no result may still be in flight
      repeat (200) @(posedge clock);
   endtask

   // mode: 0 random, 1 all black, 2 all white, 3 checkerboard extremes
   task automatic send_frame(int w, int h, int mode);
      logic [7:0] v;
      write_reg(REG_WIDTH, 16'(w));
      write_reg(REG_HEIGHT, 16'(h));
      for (int y = 0; y < h; y++)
         for (int x = 0; x < w; x++) begin
            v = ((x + y) % 2) ? 8'hFF : 8'h00;
            case (mode)
               1: send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
               2: send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
               3: send_pixel(v, v, v, ~v);
               default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                                   8'($urandom));
            endcase
         end
      drain_results();
   endtask

   initial begin
      int w, h, sent;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: extremes, single row, single column, single pixel
      send_frame(3, 3, 3);
      send_frame(2, 2, 2);
      send_frame(1, 1, 0);
      send_frame(1, 4, 0);
      send_frame(5, 1, 0);
      send_frame(2, 2, 1);
      sent = 27;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 83; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 83; end
            default: begin send_idle_pct = 27; stall_pct = 27; end
         endcase
         if (ph == 0) hold_off = 400;
         for (int f = 0; f < 3; f++) begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 5);
            send_frame(w, h, 0);
            sent += w * h;
         end
      end
      // a wide frame of two rows, and a tall narrow frame
      send_idle_pct = 0;
      stall_pct = 10;
      send_frame(48, 2, 0);
      send_frame(1, 40, 0);
      sent += 136;
      while (sent < 380) begin
         w = $urandom_range(1, 6);
         h = $urandom_range(1, 6);
         send_frame(w, h, 0);
         sent += w * h;
      end
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #(12 * 4000000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

// File: filelist.f
+incdir+design
design/rce_pkg.sv
design/rce_stream_if.sv
design/rce_ram.sv
design/rce_isqrt.sv
design/roberts_cross_edge_magnitude.sv
tb/sv/rce_edge_checker.sv
tb/sv/tb.sv
